[rtl/tkis_pkg.sv]
package tkis_pkg;

	localparam int WEIGHT_W        = 32;
	localparam int INDEX_W         = 10;
	localparam int TOP_COUNT_W     = 7;
	localparam int TOP_COUNT_RESET = 5;

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} tkis_state_t;

	typedef struct packed {
		logic insert;
		logic pop;
		logic clear;
	} tkis_cmd_t;

	typedef struct packed {
		logic head_avail;
	} tkis_sts_t;

endpackage

[rtl/tkis_col_if.sv]
interface tkis_col_if;
	logic                         valid;
	logic                         ready;
	logic [tkis_pkg::WEIGHT_W-1:0] weight;
	logic                         last_value;

	modport source (output valid, output weight, output last_value, input ready);
	modport sink   (input valid, input weight, input last_value, output ready);
endinterface

[rtl/tkis_res_if.sv]
interface tkis_res_if;
	logic                         valid;
	logic                         ready;
	logic [tkis_pkg::INDEX_W-1:0]  term_index;
	logic [tkis_pkg::WEIGHT_W-1:0] term_weight;
	logic                         last_result;

	modport source (output valid, output term_index, output term_weight,
		output last_result, input ready);
	modport sink   (input valid, input term_index, input term_weight,
		input last_result, output ready);
endinterface

[rtl/tkis_ctrl.sv]
module tkis_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                col_valid,
	input  logic                col_last,
	output logic                col_ready,
	output logic                res_valid,
	input  logic                res_ready,
	input  tkis_pkg::tkis_sts_t sts,
	output tkis_pkg::tkis_cmd_t cmd
);

	tkis_pkg::tkis_state_t state_q;
	tkis_pkg::tkis_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tkis_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tkis_pkg::ST_LOAD: begin
				if (col_valid && col_last) begin
					state_d = tkis_pkg::ST_EMIT;
				end
			end
			tkis_pkg::ST_EMIT: begin
				if (!sts.head_avail) begin
					state_d = tkis_pkg::ST_LOAD;
				end
			end
			default: state_d = tkis_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		col_ready = 1'b0;
		res_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			tkis_pkg::ST_LOAD: begin
				col_ready  = 1'b1;
				cmd.insert = col_valid;
			end
			tkis_pkg::ST_EMIT: begin
				res_valid = sts.head_avail;
				cmd.pop   = sts.head_avail && res_ready;
				cmd.clear = !sts.head_avail;
			end
			default: cmd = '0;
		endcase
	end

	a_clear_returns: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> state_q == tkis_pkg::ST_LOAD)
		else $error("clear did not return to load");

	a_no_insert_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tkis_pkg::ST_EMIT |-> !cmd.insert && !col_ready)
		else $error("word taken during emission");

	a_res_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> state_q == tkis_pkg::ST_EMIT)
		else $error("result word offered outside emission");

endmodule

[rtl/tkis_chain.sv]
module tkis_chain #(
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_TOP    = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [tkis_pkg::TOP_COUNT_W-1:0]   cfg_wr_data,
	input  logic [tkis_pkg::WEIGHT_W-1:0]      weight,
	input  tkis_pkg::tkis_cmd_t                cmd,
	output tkis_pkg::tkis_sts_t                sts,
	output logic [tkis_pkg::INDEX_W-1:0]       term_index,
	output logic [tkis_pkg::WEIGHT_W-1:0]      term_weight,
	output logic                               last_result
);

	localparam int CNT_W = $clog2(MAX_HEIGHT + 1);
	localparam int POS_W = $clog2(MAX_HEIGHT);
	localparam int LIM_W = $clog2(MAX_TOP + 1);

	logic [tkis_pkg::TOP_COUNT_W-1:0] top_count_q;
	logic [CNT_W-1:0]                 pos_cnt_q;
	logic [LIM_W-1:0]                 emit_cnt_q;
	logic [LIM_W-1:0]                 lim;
	logic [MAX_TOP-1:0]               valid_q;
	logic [MAX_TOP-1:0]               valid_nxt;
	logic [MAX_TOP-1:0]               take;
	logic [MAX_TOP-1:0]               in_lim;
	logic [tkis_pkg::WEIGHT_W-1:0]    wt_q  [MAX_TOP];
	logic [POS_W-1:0]                 pos_q [MAX_TOP];
	logic                             ins_en;

	always_comb begin
		if (top_count_q == '0) begin
			lim = LIM_W'(1);
		end else if (top_count_q > tkis_pkg::TOP_COUNT_W'(MAX_TOP)) begin
			lim = LIM_W'(MAX_TOP);
		end else begin
			lim = LIM_W'(top_count_q);
		end
	end

	assign ins_en = cmd.insert && (pos_cnt_q < CNT_W'(MAX_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_count_q <= tkis_pkg::TOP_COUNT_W'(tkis_pkg::TOP_COUNT_RESET);
			pos_cnt_q   <= '0;
			emit_cnt_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				top_count_q <= cfg_wr_data;
			end
			if (cmd.clear) begin
				pos_cnt_q  <= '0;
				emit_cnt_q <= '0;
			end else begin
				if (ins_en) begin
					pos_cnt_q <= pos_cnt_q + 1'b1;
				end
				if (cmd.pop) begin
					emit_cnt_q <= emit_cnt_q + 1'b1;
				end
			end
		end
	end

	for (genvar j = 0; j < MAX_TOP; j++) begin : g_cell
		logic take_prev;

		assign in_lim[j] = LIM_W'(j) < lim;
		assign take[j]   = in_lim[j] && (!valid_q[j] || weight > wt_q[j]);

		if (j == 0) begin : g_head
			assign take_prev = 1'b0;
		end else begin : g_body
			assign take_prev = take[j-1];
		end

		if (j == MAX_TOP - 1) begin : g_tail
			assign valid_nxt[j] = 1'b0;
		end else begin : g_mid
			assign valid_nxt[j] = valid_q[j+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q[j] <= 1'b0;
			end else if (cmd.clear) begin
				valid_q[j] <= 1'b0;
			end else if (cmd.pop) begin
				valid_q[j] <= valid_nxt[j];
			end else if (ins_en) begin
				if (!in_lim[j]) begin
					valid_q[j] <= 1'b0;
				end else if (take_prev) begin
					valid_q[j] <= (j == 0) ? 1'b0 : valid_q[(j == 0) ? 0 : j-1];
				end else if (take[j]) begin
					valid_q[j] <= 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.pop) begin
				if (j != MAX_TOP - 1) begin
					wt_q[j]  <= wt_q[(j == MAX_TOP - 1) ? j : j+1];
					pos_q[j] <= pos_q[(j == MAX_TOP - 1) ? j : j+1];
				end
			end else if (ins_en && in_lim[j]) begin
				if (take_prev) begin
					wt_q[j]  <= wt_q[(j == 0) ? 0 : j-1];
					pos_q[j] <= pos_q[(j == 0) ? 0 : j-1];
				end else if (take[j]) begin
					wt_q[j]  <= weight;
					pos_q[j] <= POS_W'(pos_cnt_q);
				end
			end
		end

		if (j > 0) begin : g_order
			a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
				valid_q[j] |-> valid_q[j-1] && wt_q[j-1] >= wt_q[j])
				else $error("kept list out of order");
		end
	end

	assign sts.head_avail = valid_q[0] && (emit_cnt_q < lim);
	assign term_weight    = wt_q[0];
	assign term_index     = tkis_pkg::INDEX_W'(pos_q[0]);
	assign last_result    = (LIM_W'(emit_cnt_q + 1'b1) == lim) || !valid_nxt[0];

	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(MAX_TOP'(valid_q + 1'b1) & valid_q) == '0)
		else $error("valid bits not contiguous");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_cnt_q <= CNT_W'(MAX_HEIGHT))
		else $error("position counter overran");

endmodule

[rtl/top_k_index_select.sv]
// The first result word is offered in the cycle after the word flagged last is taken.
// Per cycle: one column word while loading; one result word while emitting and ready is high.
// A sorted chain of compare-and-shift cells inserts each of the first MAX_HEIGHT words as it is taken.
// After the final result the list is cleared before the next column word is taken.
// Reset (arst_n low): list and position counter cleared, top_count set to 5.
module top_k_index_select #(
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_TOP    = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [tkis_pkg::TOP_COUNT_W-1:0] cfg_wr_data,
	tkis_col_if.sink                         column,
	tkis_res_if.source                       result
);

	tkis_pkg::tkis_cmd_t cmd;
	tkis_pkg::tkis_sts_t sts;

	tkis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.col_valid (column.valid),
		.col_last  (column.last_value),
		.col_ready (column.ready),
		.res_valid (result.valid),
		.res_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tkis_chain #(
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_TOP    (MAX_TOP)
	) u_chain (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.weight      (column.weight),
		.cmd         (cmd),
		.sts         (sts),
		.term_index  (result.term_index),
		.term_weight (result.term_weight),
		.last_result (result.last_result)
	);

endmodule
